/* rtl/morse_character_keyer_assert.svh */
// Assertion macros for the Morse character keyer.
`ifndef MORSE_CHARACTER_KEYER_ASSERT_SVH
`define MORSE_CHARACTER_KEYER_ASSERT_SVH

`ifndef SYNTH
// Checked only out of reset.
`define MCK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define MCK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MCK_ASSERT(lbl, prop, msg)
`define MCK_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/mck_pkg.sv */
// Package: widths, constants, types and Morse lookup for the keyer.
`timescale 1ns / 1ps

package mck_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned UnitW = 11;
  localparam int unsigned ToneW = 12;
  localparam int unsigned GapW  = 13;
  localparam int unsigned CodeW = 7;

  localparam logic [UnitW-1:0] UnitMin   = 11'd1;
  localparam logic [UnitW-1:0] UnitMax   = 11'd1200;
  localparam logic [UnitW-1:0] UnitReset = 11'd60;

  // Pattern with only the sentinel left: space or end of character.
  localparam logic [CodeW-1:0] CodeSpace = 7'h01;

  // Shared multiply-by-constant op: (unit << shift) + (add_twice ? unit << 1 : 0).
  typedef struct packed {
    logic [1:0] shift;
    logic       add_twice;
  } mck_op_t;

  localparam mck_op_t OpUnit     = '{shift: 2'd0, add_twice: 1'b0};
  localparam mck_op_t OpTriple   = '{shift: 2'd0, add_twice: 1'b1};
  localparam mck_op_t OpQuad     = '{shift: 2'd2, add_twice: 1'b0};
  localparam mck_op_t OpSextuple = '{shift: 2'd2, add_twice: 1'b1};

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StTone = 4'b0010,
    StGap  = 4'b0100,
    StOut  = 4'b1000
  } mck_state_e;

  // LSB-first pattern behind a leading 1; dit = 0, dah = 1.
  function automatic logic [CodeW-1:0] mck_lookup(input logic [CharW-1:0] c);
    logic [CodeW-1:0] code;
    case (c)
      8'h45:   code = 7'h02; // E
      8'h49:   code = 7'h04; // I
      8'h53:   code = 7'h08; // S
      8'h54:   code = 7'h03; // T
      8'h41:   code = 7'h06; // A
      8'h48:   code = 7'h10; // H
      8'h4E:   code = 7'h05; // N
      8'h44:   code = 7'h09; // D
      8'h52:   code = 7'h0A; // R
      8'h55:   code = 7'h0C; // U
      8'h46:   code = 7'h14; // F
      8'h42:   code = 7'h11; // B
      8'h47:   code = 7'h0B; // G
      8'h4C:   code = 7'h12; // L
      8'h4D:   code = 7'h07; // M
      8'h56:   code = 7'h18; // V
      8'h57:   code = 7'h0E; // W
      8'h43:   code = 7'h15; // C
      8'h4F:   code = 7'h0F; // O
      8'h4A:   code = 7'h1E; // J
      8'h4B:   code = 7'h0D; // K
      8'h51:   code = 7'h1B; // Q
      8'h50:   code = 7'h16; // P
      8'h58:   code = 7'h19; // X
      8'h5A:   code = 7'h13; // Z
      8'h59:   code = 7'h1D; // Y
      8'h30:   code = 7'h3F; // 0
      8'h31:   code = 7'h3E; // 1
      8'h32:   code = 7'h3C; // 2
      8'h33:   code = 7'h38; // 3
      8'h34:   code = 7'h30; // 4
      8'h35:   code = 7'h20; // 5
      8'h36:   code = 7'h21; // 6
      8'h37:   code = 7'h23; // 7
      8'h38:   code = 7'h27; // 8
      8'h39:   code = 7'h2F; // 9
      8'h3F:   code = 7'h4C; // ?
      8'h2E:   code = 7'h6A; // .
      8'h2C:   code = 7'h73; // ,
      8'h3D:   code = 7'h31; // =
      8'h2F:   code = 7'h29; // /
      8'h3A:   code = 7'h47; // :
      8'h21:   code = 7'h75; // !
      8'h2D:   code = 7'h61; // -
      8'h27:   code = 7'h5E; // apostrophe
      8'h2B:   code = 7'h2A; // +
      default: code = CodeSpace; // space and anything unknown
    endcase
    return code;
  endfunction

endpackage

/* rtl/mck_char_if.sv */
// Input channel: one ASCII character per beat.
`timescale 1ns / 1ps

interface mck_char_if import mck_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

/* rtl/mck_elem_if.sv */
// Output channel: one Morse element per beat.
`timescale 1ns / 1ps

interface mck_elem_if import mck_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ToneW-1:0] tone_ms;
  logic [GapW-1:0]  gap_ms;
  logic             is_dah;
  logic             last;

  modport source (output valid, output tone_ms, output gap_ms, output is_dah,
                  output last, input ready);
  modport sink   (input valid, input tone_ms, input gap_ms, input is_dah,
                  input last, output ready);
endinterface

/* rtl/morse_character_keyer.sv */
// A character beat is followed by the lookup, tone and gap steps, then the first element;
// a space skips the gap step. Each element walks tone, gap and output, waiting in output
// while the output stalls; tone and gap share one adder. A character has 1 to 6 elements.
// Not ready while a character is in flight; ready again the cycle after its last beat.
// Reset (async, active low): idle, unit length back to 60 ms, no element pending.
`timescale 1ns / 1ps

`include "morse_character_keyer_assert.svh"

module morse_character_keyer import mck_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [UnitW-1:0] cfg_wdata_i,
  mck_char_if.sink         char_if,
  mck_elem_if.source       elem_if
);

  // Unit length register; sampled and clamped when a character is taken.
  logic [UnitW-1:0] unit_cfg_q;

  // Sequencer <-> shared shift-add unit.
  logic [UnitW-1:0] alu_unit;
  mck_op_t          alu_op;
  logic [GapW-1:0]  alu_res;

  // Element beat on the output channel.
  logic             elem_beat;

  assign elem_beat = elem_if.valid && elem_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_cfg_q <= UnitReset;
    end else if (cfg_we_i) begin
      unit_cfg_q <= cfg_wdata_i;
    end
  end

  // One adder does every multiply: x1, x3 (dah), x4 (final gap), x6 (space).
  mck_alu u_alu (
    .unit_i (alu_unit),
    .op_i   (alu_op),
    .res_o  (alu_res)
  );

  // Lookup, element walk and output register.
  mck_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_unit_i (unit_cfg_q),
    .char_if    (char_if),
    .elem_if    (elem_if),
    .unit_o     (alu_unit),
    .op_o       (alu_op),
    .res_i      (alu_res)
  );

  // One character at a time: never taking input while an element is offered.
  `MCK_ASSERT(a_busy_excl, !(char_if.ready && elem_if.valid), "ready while element pending")
  // Final beat frees the block.
  `MCK_ASSERT(a_last_frees, elem_beat && elem_if.last |=> char_if.ready, "busy after last beat")
  // A non-final beat keeps it busy.
  `MCK_ASSERT(a_mid_busy, elem_beat && !elem_if.last |=> !char_if.ready, "ready mid character")
  // Every element carries a nonzero gap.
  `MCK_ASSERT(a_gap_nonzero, elem_if.valid |-> elem_if.gap_ms != '0, "zero gap element")

endmodule

/* rtl/mck_alu.sv */
// Shared shift-add unit: unit length times 1, 3, 4 or 6.
`timescale 1ns / 1ps

module mck_alu import mck_pkg::*; (
  input  logic [UnitW-1:0] unit_i,
  input  mck_op_t          op_i,
  output logic [GapW-1:0]  res_o
);

  logic [GapW-1:0] base;
  logic [GapW-1:0] twice;

  always_comb begin
    base  = {{(GapW-UnitW){1'b0}}, unit_i} << op_i.shift;
    twice = op_i.add_twice ? {{(GapW-UnitW-1){1'b0}}, unit_i, 1'b0} : '0;
    res_o = base + twice;
  end

endmodule

/* rtl/mck_seq.sv */
// Sequencer: looks up the character and walks its pattern one element at a time.
`timescale 1ns / 1ps

module mck_seq import mck_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [UnitW-1:0] cfg_unit_i,
  mck_char_if.sink         char_if,
  mck_elem_if.source       elem_if,
  output logic [UnitW-1:0] unit_o,
  output mck_op_t          op_o,
  input  logic [GapW-1:0]  res_i
);

  mck_state_e       state_q, state_d;
  logic [CodeW-1:0] code_q, code_d;
  logic [UnitW-1:0] unit_q, unit_d;
  logic [ToneW-1:0] tone_q, tone_d;
  logic [GapW-1:0]  gap_q, gap_d;
  logic             dah_q, dah_d;
  logic             last_q, last_d;
  logic             is_space;
  logic             fin;

  assign is_space = (code_q == CodeSpace);
  // Next shift leaves only the sentinel: this is the final element.
  assign fin      = (code_q[CodeW-1:1] == CodeSpace[CodeW-2:0]);

  assign char_if.ready   = (state_q == StIdle);
  assign elem_if.valid   = (state_q == StOut);
  assign elem_if.tone_ms = tone_q;
  assign elem_if.gap_ms  = gap_q;
  assign elem_if.is_dah  = dah_q;
  assign elem_if.last    = last_q;
  assign unit_o          = unit_q;

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    unit_d  = unit_q;
    tone_d  = tone_q;
    gap_d   = gap_q;
    dah_d   = dah_q;
    last_d  = last_q;
    op_o    = OpUnit;
    case (state_q)
      StIdle: begin
        if (char_if.valid) begin
          code_d = mck_lookup(char_if.char_code);
          if (cfg_unit_i < UnitMin) begin
            unit_d = UnitMin;
          end else if (cfg_unit_i > UnitMax) begin
            unit_d = UnitMax;
          end else begin
            unit_d = cfg_unit_i;
          end
          state_d = StTone;
        end
      end
      StTone: begin
        if (is_space) begin
          op_o    = OpSextuple;
          tone_d  = '0;
          gap_d   = res_i;
          dah_d   = 1'b0;
          last_d  = 1'b1;
          state_d = StOut;
        end else begin
          op_o    = code_q[0] ? OpTriple : OpUnit;
          tone_d  = res_i[ToneW-1:0];
          dah_d   = code_q[0];
          state_d = StGap;
        end
      end
      StGap: begin
        op_o    = fin ? OpQuad : OpUnit;
        gap_d   = res_i;
        last_d  = fin;
        code_d  = code_q >> 1;
        state_d = StOut;
      end
      StOut: begin
        if (elem_if.ready) begin
          state_d = last_q ? StIdle : StTone;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    unit_q <= unit_d;
    tone_q <= tone_d;
    gap_q  <= gap_d;
    dah_q  <= dah_d;
  end

endmodule
